FILE: src/ipv4_first_match_access_list_assert.svh
// Assertion macros for the access list block.
`ifndef IPV4_FIRST_MATCH_ACCESS_LIST_ASSERT_SVH
`define IPV4_FIRST_MATCH_ACCESS_LIST_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define FMACL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define FMACL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/fmacl_pkg.sv
`default_nettype none

package fmacl_pkg;

  // Item kinds
  localparam logic [1:0] KIND_LOOKUP = 2'd0;
  localparam logic [1:0] KIND_ADD    = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  // Field widths
  localparam int ADDR_W   = 32;
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 8;
  localparam int RULE_W   = 2 * ADDR_W + 1;

  // Sequencer steps
  localparam int STEP_W = 3;
  typedef logic [STEP_W-1:0] step_t;
  localparam step_t S_IDLE = 3'd0;
  localparam step_t S_SCAN = 3'd1;
  localparam step_t S_ADD  = 3'd2;
  localparam step_t S_CLR  = 3'd3;
  localparam step_t S_DONE = 3'd4;

  // Jump conditions
  typedef logic [1:0] cond_t;
  localparam cond_t COND_ALWAYS   = 2'd0;
  localparam cond_t COND_DISPATCH = 2'd1;
  localparam cond_t COND_SCAN_END = 2'd2;
  localparam cond_t COND_OUT_FREE = 2'd3;

  // Datapath operations
  typedef logic [2:0] op_t;
  localparam op_t OP_NONE  = 3'd0;
  localparam op_t OP_LATCH = 3'd1;
  localparam op_t OP_SCAN  = 3'd2;
  localparam op_t OP_ADD   = 3'd3;
  localparam op_t OP_CLEAR = 3'd4;
  localparam op_t OP_EMIT  = 3'd5;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t tgt_t;
    step_t tgt_f;
  } ctrl_word_t;

  // Strobes from sequencer to datapath
  typedef struct packed {
    logic latch;
    logic scan;
    logic add;
    logic clear;
    logic emit;
  } dp_ctrl_t;

  // Flags from datapath back to sequencer
  typedef struct packed {
    logic scan_end;
    logic out_free;
  } dp_status_t;

  // Microprogram
  function automatic ctrl_word_t ucode(input step_t step);
    ctrl_word_t w;
    unique case (step)
      S_IDLE:  w = '{op: OP_LATCH, cond: COND_DISPATCH, tgt_t: S_IDLE, tgt_f: S_IDLE};
      S_SCAN:  w = '{op: OP_SCAN,  cond: COND_SCAN_END, tgt_t: S_DONE, tgt_f: S_SCAN};
      S_ADD:   w = '{op: OP_ADD,   cond: COND_ALWAYS,   tgt_t: S_DONE, tgt_f: S_DONE};
      S_CLR:   w = '{op: OP_CLEAR, cond: COND_ALWAYS,   tgt_t: S_DONE, tgt_f: S_DONE};
      S_DONE:  w = '{op: OP_EMIT,  cond: COND_OUT_FREE, tgt_t: S_IDLE, tgt_f: S_DONE};
      default: w = '{op: OP_NONE,  cond: COND_ALWAYS,   tgt_t: S_IDLE, tgt_f: S_IDLE};
    endcase
    return w;
  endfunction

  // Dispatch target for a freshly accepted beat
  function automatic step_t kind_step(input logic [1:0] kind);
    step_t s;
    unique case (kind)
      KIND_LOOKUP: s = S_SCAN;
      KIND_ADD:    s = S_ADD;
      KIND_CLEAR:  s = S_CLR;
      default:     s = S_DONE;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

FILE: src/fmacl_ram.sv
`default_nettype none

module fmacl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: src/fmacl_seq.sv
`default_nettype none

module fmacl_seq (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_fire,
  input  wire logic [1:0]            in_kind,
  input  wire fmacl_pkg::dp_status_t status,
  output fmacl_pkg::dp_ctrl_t        ctrl,
  output logic                       idle
);

  fmacl_pkg::step_t      step_r, step_nxt;
  fmacl_pkg::ctrl_word_t word;

  assign word = fmacl_pkg::ucode(step_r);
  assign idle = (step_r == fmacl_pkg::S_IDLE);

  // Decode the operation field into strobes
  always_comb begin
    ctrl = '0;
    unique case (word.op)
      fmacl_pkg::OP_LATCH: ctrl.latch = in_fire;
      fmacl_pkg::OP_SCAN:  ctrl.scan  = 1'b1;
      fmacl_pkg::OP_ADD:   ctrl.add   = 1'b1;
      fmacl_pkg::OP_CLEAR: ctrl.clear = 1'b1;
      fmacl_pkg::OP_EMIT:  ctrl.emit  = status.out_free;
      default:             ctrl       = '0;
    endcase
  end

  // Select the next step
  always_comb begin
    unique case (word.cond)
      fmacl_pkg::COND_ALWAYS:   step_nxt = word.tgt_t;
      fmacl_pkg::COND_DISPATCH: step_nxt = in_fire ? fmacl_pkg::kind_step(in_kind) : word.tgt_f;
      fmacl_pkg::COND_SCAN_END: step_nxt = status.scan_end ? word.tgt_t : word.tgt_f;
      fmacl_pkg::COND_OUT_FREE: step_nxt = status.out_free ? word.tgt_t : word.tgt_f;
      default:                  step_nxt = fmacl_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= fmacl_pkg::S_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: src/fmacl_dp.sv
`default_nettype none

module fmacl_dp #(
  parameter int RULE_CAPACITY = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire fmacl_pkg::dp_ctrl_t           ctrl,
  input  wire logic [fmacl_pkg::ADDR_W-1:0]  in_address,
  input  wire logic [fmacl_pkg::ADDR_W-1:0]  in_netmask,
  input  wire logic                          in_include,
  input  wire logic                          out_ready,
  output fmacl_pkg::dp_status_t              status,
  output logic                               out_valid,
  output logic [2:0]                         out_flags
);

  localparam int AW = (RULE_CAPACITY > 1) ? $clog2(RULE_CAPACITY) : 1;
  localparam int CW = $clog2(RULE_CAPACITY + 1);
  localparam logic [CW-1:0] CAP = CW'(RULE_CAPACITY);

  logic [fmacl_pkg::ADDR_W-1:0] addr_r, mask_r;
  logic                         incl_r;
  logic [CW-1:0]                idx_r, count_r;
  logic                         pend_r;
  logic                         matched_r, accepted_r, add_ok_r;
  logic                         out_valid_r;
  logic [2:0]                   out_flags_r;

  logic [fmacl_pkg::RULE_W-1:0] rd_data;
  logic [fmacl_pkg::ADDR_W-1:0] rd_net, rd_mask;
  logic                         rd_incl;
  logic                         hit, idx_done, scan_end, issue;
  logic                         add_legal, wr_en;

  assign rd_net  = rd_data[fmacl_pkg::ADDR_W-1:0];
  assign rd_mask = rd_data[2*fmacl_pkg::ADDR_W-1:fmacl_pkg::ADDR_W];
  assign rd_incl = rd_data[fmacl_pkg::RULE_W-1];

  // Compare the rule fetched last cycle; fetch the next while none has hit and rules remain
  assign hit      = pend_r && ((addr_r & rd_mask) == rd_net);
  assign idx_done = (idx_r >= count_r);
  assign scan_end = hit || idx_done;
  assign issue    = ctrl.scan && !scan_end;

  assign add_legal = ((addr_r & ~mask_r) == '0) && (count_r < CAP);
  assign wr_en     = ctrl.add && add_legal;

  assign status.scan_end = scan_end;
  assign status.out_free = !out_valid_r || out_ready;

  fmacl_ram #(
    .WIDTH (fmacl_pkg::RULE_W),
    .DEPTH (RULE_CAPACITY),
    .AW    (AW)
  ) u_rules (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[AW-1:0]),
    .wr_data ({incl_r, mask_r, addr_r}),
    .rd_en   (issue),
    .rd_addr (idx_r[AW-1:0]),
    .rd_data (rd_data)
  );

  // Item registers and result flags
  always_ff @(posedge clk) begin
    if (ctrl.latch) begin
      addr_r     <= in_address;
      mask_r     <= in_netmask;
      incl_r     <= in_include;
      matched_r  <= 1'b0;
      accepted_r <= 1'b0;
      add_ok_r   <= 1'b0;
    end else begin
      if (ctrl.scan && hit) begin
        matched_r  <= 1'b1;
        accepted_r <= rd_incl;
      end
      if (wr_en) begin
        add_ok_r <= 1'b1;
      end
    end
    if (ctrl.emit) begin
      out_flags_r <= {add_ok_r, matched_r, accepted_r};
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      pend_r      <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctrl.latch) begin
        idx_r  <= '0;
        pend_r <= 1'b0;
      end else if (ctrl.scan) begin
        pend_r <= issue;
        if (issue) begin
          idx_r <= idx_r + CW'(1);
        end
      end
      if (ctrl.clear) begin
        count_r <= '0;
      end else if (wr_en) begin
        count_r <= count_r + CW'(1);
      end
      if (ctrl.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_flags = out_flags_r;

endmodule

`default_nettype wire

FILE: src/ipv4_first_match_access_list.sv
`default_nettype none

// First-match IPv4 access list. Each input beat carries a kind in in_tuser: lookup, add
// rule or clear. An add appends {network, netmask, include} to an ordered table of
// RULE_CAPACITY entries and is refused (add_ok 0) if the network has bits outside the
// mask or the table is full; a clear empties the table; a lookup walks the rules in
// insertion order and the first one with (address & netmask) == network decides accept
// or reject, no match meaning reject. Every beat in gives exactly one result beat out.
// Items are handled one at a time by a small microcoded sequencer. An add or a clear passes
// from the idle step through its own step and the done step back to idle; a lookup stays in
// the scan step until a rule hits or all stored rules are read, because the rule table
// sits in a single-port-read RAM and is read one rule per cycle. A finished result is
// held in an output register until taken; a stalled output holds the sequencer in its
// final step. No clearing pass is needed after reset: the count and control state are reset, not the table.

`include "ipv4_first_match_access_list_assert.svh"

module ipv4_first_match_access_list #(
  parameter int RULE_CAPACITY = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // in_tdata: address [31:0], netmask [63:32], include_req [64], zero fill [71:65]
  input  wire logic [fmacl_pkg::IN_DATA_W-1:0]    in_tdata,
  // in_tuser: kind [1:0]
  input  wire logic [1:0]                         in_tuser,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // out_tdata: accepted [0], matched [1], add_ok [2], zero fill [7:3]
  output logic [fmacl_pkg::OUT_DATA_W-1:0]        out_tdata,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready
);

  logic                  in_fire;
  logic                  idle;
  logic [2:0]            out_flags;
  fmacl_pkg::dp_ctrl_t   ctrl;
  fmacl_pkg::dp_status_t status;

  // Take a beat only out of reset and when the sequencer is back at its idle step
  assign in_tready = idle && rst_n;
  assign in_fire   = in_tvalid && in_tready;

  fmacl_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_kind (in_tuser),
    .status  (status),
    .ctrl    (ctrl),
    .idle    (idle)
  );

  fmacl_dp #(
    .RULE_CAPACITY (RULE_CAPACITY)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .in_address (in_tdata[31:0]),
    .in_netmask (in_tdata[63:32]),
    .in_include (in_tdata[64]),
    .out_ready  (out_tready),
    .status     (status),
    .out_valid  (out_tvalid),
    .out_flags  (out_flags)
  );

  // Pad the result flags to a whole byte
  assign out_tdata = {{(fmacl_pkg::OUT_DATA_W - 3){1'b0}}, out_flags};

  // A beat taken must leave the block busy in the next cycle
  `FMACL_ASSERT_NEXT(a_busy_after_accept, in_fire, !in_tready, "ready held after accept")
  // Accept only ever comes from a matching rule
  `FMACL_ASSERT_NOW(a_accept_needs_match, out_tvalid && out_tdata[0], out_tdata[1], "bad accept")
  // A stored rule and a lookup hit never share one result
  `FMACL_ASSERT_NOW(a_add_not_lookup, out_tvalid && out_tdata[2], ~|out_tdata[1:0], "add with hit")

endmodule

`default_nettype wire
